/* rtl/irbt_pkg.sv */
// Shared types and constants for the bi-phase IR transmitter.
package irbt_pkg;

    localparam int MSG_W       = 12;
    localparam int LEN_W       = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;

    localparam int MESSAGE_BITS_DEFAULT = 12;
    localparam int START_BITS           = 2;

    localparam logic [LEN_W-1:0] HALF_BIT_RESET = 16'd889;
    localparam logic [LEN_W-1:0] GAP_RESET      = 16'd50000;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_HALF_BIT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAP      = 1'd1;

    // Sequencer stage codes.
    localparam logic [1:0] STAGE_IDLE = 2'd0;
    localparam logic [1:0] STAGE_LEAD = 2'd1;
    localparam logic [1:0] STAGE_BITS = 2'd2;
    localparam logic [1:0] STAGE_GAP  = 2'd3;

    // Control from the sequencer to the phase timer.
    typedef struct packed {
        logic clear;
        logic advance;
        logic in_gap;
    } tmr_ctrl_t;

endpackage

/* rtl/irbt_timer.sv */
// Phase timer: counts ticks against the half-bit or gap length.
module irbt_timer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  irbt_pkg::tmr_ctrl_t          ctrl,
    input  logic [irbt_pkg::LEN_W-1:0]   half_bit_ticks,
    input  logic [irbt_pkg::LEN_W-1:0]   gap_ticks,
    output logic                         phase_end
);
    import irbt_pkg::*;

    logic [LEN_W-1:0] tick_count_reg;
    logic [LEN_W-1:0] tick_count_next;
    logic [LEN_W:0]   count_inc;
    logic [LEN_W-1:0] len;

    // A length of zero behaves like one since the incremented count is never zero.
    assign len       = ctrl.in_gap ? gap_ticks : half_bit_ticks;
    assign count_inc = {1'b0, tick_count_reg} + {{LEN_W{1'b0}}, 1'b1};
    assign phase_end = ctrl.advance && (count_inc >= {1'b0, len});

    always_comb
    begin
        tick_count_next = tick_count_reg;
        if (ctrl.clear)
        begin
            tick_count_next = '0;
        end
        else if (ctrl.advance)
        begin
            tick_count_next = phase_end ? '0 : count_inc[LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
        end
        else
        begin
            tick_count_reg <= tick_count_next;
        end
    end

endmodule

/* rtl/irbt_sequencer.sv */
// Frame sequencer: latches the frame and steps the LED through the bi-phase code.
module irbt_sequencer #(
    parameter int MESSAGE_BITS = irbt_pkg::MESSAGE_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_fire,
    input  logic                         op,
    input  logic [irbt_pkg::MSG_W-1:0]   message,
    input  logic                         phase_end,
    output irbt_pkg::tmr_ctrl_t          tmr_ctrl,
    output logic                         led_next,
    output logic                         ready_next,
    output logic                         accepted_next
);
    import irbt_pkg::*;

    localparam int FRAME_BITS = MESSAGE_BITS + START_BITS;
    localparam int IDX_W      = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BITS - 1);

    logic [FRAME_BITS-1:0] frame_shift_reg, frame_shift_next;
    logic [IDX_W-1:0]      bit_index_reg, bit_index_next;
    logic                  second_half_reg, second_half_next;
    logic [1:0]            stage_reg, stage_next;
    logic                  led_level_reg, led_level_next;

    logic [MSG_W+MESSAGE_BITS-1:0] msg_wide;
    logic [MESSAGE_BITS-1:0]       msg_ext;
    logic                          start;
    logic                          busy;
    logic [IDX_W-1:0]              idx_inc;

    // Zero-extend or truncate the message port to the configured length.
    assign msg_wide = {{MESSAGE_BITS{1'b0}}, message};
    assign msg_ext  = msg_wide[MESSAGE_BITS-1:0];

    assign busy    = (stage_reg != STAGE_IDLE);
    assign start   = item_fire && op && !busy;
    assign idx_inc = bit_index_reg + IDX_W'(1);

    assign tmr_ctrl.clear   = start;
    assign tmr_ctrl.advance = item_fire && !op && busy;
    assign tmr_ctrl.in_gap  = (stage_reg == STAGE_GAP);

    always_comb
    begin
        frame_shift_next = frame_shift_reg;
        bit_index_next   = bit_index_reg;
        second_half_next = second_half_reg;
        stage_next       = stage_reg;
        led_level_next   = led_level_reg;
        if (start)
        begin
            frame_shift_next = {msg_ext, 2'b11};
            bit_index_next   = '0;
            second_half_next = 1'b0;
            stage_next       = STAGE_LEAD;
            led_level_next   = 1'b1;
        end
        else if (phase_end)
        begin
            unique case (stage_reg)
                STAGE_LEAD:
                begin
                    stage_next       = STAGE_BITS;
                    bit_index_next   = '0;
                    second_half_next = 1'b0;
                    led_level_next   = ~frame_shift_reg[0];
                end
                STAGE_BITS:
                begin
                    if (!second_half_reg)
                    begin
                        led_level_next   = frame_shift_reg[bit_index_reg];
                        second_half_next = 1'b1;
                    end
                    else if (bit_index_reg >= LAST_IDX)
                    begin
                        stage_next     = STAGE_GAP;
                        led_level_next = 1'b0;
                    end
                    else
                    begin
                        bit_index_next   = idx_inc;
                        second_half_next = 1'b0;
                        led_level_next   = ~frame_shift_reg[idx_inc];
                    end
                end
                STAGE_GAP:
                begin
                    stage_next = STAGE_IDLE;
                end
                default:
                begin
                    stage_next = stage_reg;
                end
            endcase
        end
    end

    assign led_next      = led_level_next;
    assign ready_next    = (stage_next == STAGE_IDLE);
    assign accepted_next = start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_shift_reg <= '0;
            bit_index_reg   <= '0;
            second_half_reg <= 1'b0;
            stage_reg       <= STAGE_IDLE;
            led_level_reg   <= 1'b0;
        end
        else
        begin
            frame_shift_reg <= frame_shift_next;
            bit_index_reg   <= bit_index_next;
            second_half_reg <= second_half_next;
            stage_reg       <= stage_next;
            led_level_reg   <= led_level_next;
        end
    end

endmodule

/* rtl/irbt_out_buffer.sv */
// Two-entry output buffer that decouples result delivery from item intake.
module irbt_out_buffer (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  logic push_led,
    input  logic push_ready,
    input  logic push_accepted,
    output logic full,
    output logic out_valid,
    input  logic out_stall,
    output logic led_on,
    output logic ready_res,
    output logic accepted
);
    logic       out_valid_reg, out_valid_next;
    logic       skid_valid_reg, skid_valid_next;
    logic [2:0] out_data_reg, out_data_next;
    logic [2:0] skid_data_reg, skid_data_next;
    logic       out_fire;

    assign out_fire = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_fire)
        begin
            out_valid_next = skid_valid_reg;
            out_data_next  = skid_data_reg;
            skid_valid_next = 1'b0;
        end
        if (push)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_valid_next = 1'b1;
                out_data_next  = {push_led, push_ready, push_accepted};
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = {push_led, push_ready, push_accepted};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign led_on    = out_data_reg[2];
    assign ready_res = out_data_reg[1];
    assign accepted  = out_data_reg[0];

endmodule

/* rtl/ir_biphase_transmitter.sv */
// Top level of the bi-phase (Manchester) IR transmitter.
//
// This block drives an IR LED with an RC5-style bi-phase frame. A send item
// (op = 1) is taken up only while the block is idle: it latches the message
// with two 1 start bits below it, turns the LED on for one half-bit, then
// sends every frame bit, least significant first, as its inverse level for
// one half-bit and its true level for the next. After the last bit the LED
// stays off for the idle gap, and then the block is ready again. Sends that
// arrive while busy are dropped and reported with accepted = 0. Tick items
// (op = 0) advance the phase timer; half_bit_ticks and gap_ticks give the
// phase lengths in ticks, a length of zero behaves like one, and a length
// changed in the middle of a phase applies at once. Every item gives exactly
// one result item, which shows the LED level, the idle flag and the accepted
// flag after that item. The block takes one item per clock cycle while
// in_stall is low: the state update is a single 16-bit increment and compare
// plus a bit select, done in the cycle the item is accepted, and the result
// is registered in the output buffer. A two-entry output buffer holds results
// while the receiver stalls, so in_stall rises only once two results are
// waiting. Configuration writes take effect at the clock edge where cfg_write
// is high and should be made only while no items are in flight.
module ir_biphase_transmitter #(
    parameter int MESSAGE_BITS = irbt_pkg::MESSAGE_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              op,
    input  logic [irbt_pkg::MSG_W-1:0]        message,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              led_on,
    output logic                              ready_res,
    output logic                              accepted,
    input  logic                              cfg_write,
    input  logic [irbt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [irbt_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import irbt_pkg::*;

    logic [LEN_W-1:0] half_bit_ticks_reg;
    logic [LEN_W-1:0] gap_ticks_reg;

    logic      item_fire;
    logic      buf_full;
    logic      phase_end;
    tmr_ctrl_t tmr_ctrl;
    logic      led_next;
    logic      ready_next;
    logic      accepted_next;

    // An item is taken whenever the output buffer has a free entry.
    assign in_stall  = buf_full;
    assign item_fire = in_valid && !buf_full;

    // Configuration registers; both indexes are defined, so every write lands.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_bit_ticks_reg <= HALF_BIT_RESET;
            gap_ticks_reg      <= GAP_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_HALF_BIT: half_bit_ticks_reg <= cfg_data[LEN_W-1:0];
                REG_GAP:      gap_ticks_reg      <= cfg_data[LEN_W-1:0];
                default:      half_bit_ticks_reg <= half_bit_ticks_reg;
            endcase
        end
    end

    irbt_timer u_timer (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (tmr_ctrl),
        .half_bit_ticks (half_bit_ticks_reg),
        .gap_ticks      (gap_ticks_reg),
        .phase_end      (phase_end)
    );

    irbt_sequencer #(
        .MESSAGE_BITS (MESSAGE_BITS)
    ) u_sequencer (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_fire     (item_fire),
        .op            (op),
        .message       (message),
        .phase_end     (phase_end),
        .tmr_ctrl      (tmr_ctrl),
        .led_next      (led_next),
        .ready_next    (ready_next),
        .accepted_next (accepted_next)
    );

    irbt_out_buffer u_out_buffer (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (item_fire),
        .push_led      (led_next),
        .push_ready    (ready_next),
        .push_accepted (accepted_next),
        .full          (buf_full),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .led_on        (led_on),
        .ready_res     (ready_res),
        .accepted      (accepted)
    );

endmodule

/* rtl/irbt_checker.sv */
// Port-level checker for the bi-phase IR transmitter, bound to the top level.
module irbt_checker (
    input logic clk,
    input logic rst_n,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic led_on,
    input logic ready_res,
    input logic accepted
);

    // A send that starts leaves the block busy with the LED on.
    a_accept_starts_lead: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && accepted) |-> (led_on && !ready_res))
        else $error("accepted send did not start the lead half-bit");

    // The LED is dark whenever the block reports idle.
    a_idle_led_off: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ready_res) |-> !led_on)
        else $error("LED on while idle");

    // A result taken by the receiver always frees intake on the next cycle.
    a_drain_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> !in_stall)
        else $error("input still stalled after a result was taken");

    // A stalled result holds.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(led_on) && $stable(ready_res) && $stable(accepted)))
        else $error("stalled result changed");

endmodule

bind ir_biphase_transmitter irbt_checker u_irbt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .led_on    (led_on),
    .ready_res (ready_res),
    .accepted  (accepted)
);
